// ----- hdl/sorted_list_insert_delete_assert.svh -----
// Assertion macros for the sorted list block.
// Each check is sampled on the rising clock edge and is muted while reset is held.
`ifndef SORTED_LIST_INSERT_DELETE_ASSERT_SVH
`define SORTED_LIST_INSERT_DELETE_ASSERT_SVH

`ifndef SYNTHESIS

// The condition cons must hold in the same cycle as ante.
`define SLID_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted list check failed");

// The condition cons must hold in the cycle after ante.
`define SLID_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted list check failed");

`else

`define SLID_ASSERT_NOW(lbl, ante, cons)
`define SLID_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- hdl/slid_pkg.sv -----
package slid_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = 4;
    localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int VAL_W    = 32;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_UNUSED = 2'd3
    } cell_op_t;

    // What one cell hands to the cell above it
    typedef struct packed {
        logic signed [VAL_W-1:0] entry;
        logic                    less;
        logic                    hit;
    } cell_link_t;

endpackage

// ----- hdl/slid_cell.sv -----
module slid_cell
    import slid_pkg::*;
(
    input  logic                    clk,
    input  cell_op_t                op,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    occ,
    input  cell_link_t              prev,
    input  logic signed [VAL_W-1:0] next_entry,
    output cell_link_t              link
);

    logic signed [VAL_W-1:0] entry_reg;
    logic signed [VAL_W-1:0] entry_next;
    logic                    less;
    logic                    hit;

    // Compare the stored word against the request
    assign less = occ && (entry_reg < value);
    assign hit  = (occ && (entry_reg == value)) || prev.hit;

    assign link.entry = entry_reg;
    assign link.less  = less;
    assign link.hit   = hit;

    // Keep, take the new word, or shift with a neighbor
    always_comb
    begin
        entry_next = entry_reg;
        unique case (op)
            CELL_INSERT:
            begin
                if (!less)
                begin
                    entry_next = prev.less ? value : prev.entry;
                end
            end
            CELL_DELETE:
            begin
                if (hit)
                begin
                    entry_next = next_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- hdl/sorted_list_insert_delete.sv -----
// Sorted list: a row of cells, one stored word each, updated in parallel.
// Each result is registered; the output register loads it as its word is taken.
// Throughput: one word per cycle unless stalled; one compare-and-shift pass sets it.
// Reset clears the stored-word count and the output valid; stored words stay undefined
// until written and are never read beyond the count.
`include "sorted_list_insert_delete_assert.svh"

module sorted_list_insert_delete
    import slid_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              req_type,
    input  logic signed [VAL_W-1:0] value,
    input  logic [IDX_W-1:0]        index,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              status,
    output logic signed [VAL_W-1:0] read_value,
    output logic [4:0]              entry_count
);

    logic                    in_acc;
    req_type_t               req;
    logic                    full;
    logic                    found;
    cell_op_t                op;
    logic [CMP_W-1:0]        idx_ext;
    logic [CMP_W-1:0]        cnt_ext;
    logic signed [VAL_W-1:0] rd_mux;

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    out_valid_reg;
    status_t                 status_reg;
    status_t                 status_next;
    logic signed [VAL_W-1:0] read_value_reg;
    logic signed [VAL_W-1:0] read_value_next;
    logic [4:0]              entry_count_reg;

    cell_link_t              links [CAPACITY];
    cell_link_t              prevs [CAPACITY];
    logic signed [VAL_W-1:0] nexts [CAPACITY];

    // Take a new word whenever the output register is free or draining
    assign in_stall = out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;
    assign req      = req_type_t'(req_type);

    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign found   = links[CAPACITY-1].hit;
    assign idx_ext = CMP_W'(index);
    assign cnt_ext = CMP_W'(count_reg);

    // Drive the cell row
    always_comb
    begin
        op = CELL_HOLD;
        if (in_acc)
        begin
            unique case (req)
                REQ_INSERT: op = full ? CELL_HOLD : CELL_INSERT;
                REQ_DELETE: op = CELL_DELETE;
                default:    op = CELL_HOLD;
            endcase
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign prevs[i] = '{entry: '0, less: 1'b1, hit: 1'b0};
        end
        else
        begin : g_mid
            assign prevs[i] = links[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign nexts[i] = '0;
        end
        else
        begin : g_upper
            assign nexts[i] = links[i+1].entry;
        end

        slid_cell u_cell (
            .clk        (clk),
            .op         (op),
            .value      (value),
            .occ        (count_reg > CNT_W'(i)),
            .prev       (prevs[i]),
            .next_entry (nexts[i]),
            .link       (links[i])
        );
    end

    // Select the word at the read position
    always_comb
    begin
        rd_mux = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (idx_ext == CMP_W'(i))
            begin
                rd_mux = links[i].entry;
            end
        end
    end

    // Form the result and the new count
    always_comb
    begin
        status_next     = ST_OK;
        read_value_next = '0;
        count_next      = count_reg;
        unique case (req)
            REQ_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_DELETE:
            begin
                if (found)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            REQ_READ:
            begin
                if (idx_ext < cnt_ext)
                begin
                    read_value_next = rd_mux;
                end
                else
                begin
                    status_next = ST_BAD_INDEX;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            status_reg      <= status_next;
            read_value_reg  <= read_value_next;
            entry_count_reg <= 5'(count_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;

    `SLID_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SLID_ASSERT_NEXT(a_insert_grows, in_acc && req == REQ_INSERT && !full, count_reg == $past(count_reg) + CNT_W'(1))
    `SLID_ASSERT_NOW(a_full_flag, out_valid_reg && status_reg == ST_FULL, count_reg == CNT_W'(CAPACITY))
    `SLID_ASSERT_NOW(a_ordered, count_reg >= CNT_W'(2), links[0].entry <= links[1].entry)

endmodule
